// ===== rtl/simeck_pkg.sv =====
// ----------------------------------------------------------------------------
// simeck_pkg
// Shared constants, register indexes and the round mixing function for the
// reduced-round Simeck32/64 encryption core.
// ----------------------------------------------------------------------------
package simeck_pkg;

    localparam int ROUNDS_DEF = 15;
    localparam int ROUNDS_MAX = 32;
    localparam int HALF_W     = 16;
    localparam int CONST_BITS = 14;
    localparam int CFG_IDX_W  = 3;

    localparam logic [HALF_W-1:0] CONST_BASE = 16'hfffc;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0  = 3'd0,
        CFG_KEY1  = 3'd1,
        CFG_KEY2  = 3'd2,
        CFG_KEY3  = 3'd3,
        CFG_CONST = 3'd4
    } t_cfg_idx;

    localparam logic [HALF_W-1:0]     KEY0_RST  = 16'h60ed;
    localparam logic [HALF_W-1:0]     KEY1_RST  = 16'h1c3d;
    localparam logic [HALF_W-1:0]     KEY2_RST  = 16'h9c31;
    localparam logic [HALF_W-1:0]     KEY3_RST  = 16'h32ad;
    localparam logic [CONST_BITS-1:0] CONST_RST = 14'h3b1f;

    // (rol5(a) & a) ^ rol1(a)
    function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] a);
        return ({a[10:0], a[15:11]} & a) ^ {a[14:0], a[15]};
    endfunction

endpackage

// ===== rtl/simeck32_64_encrypt_core.sv =====
// Throughput: one word per cycle; one register stage per round, with the key
// schedule step for that round carried alongside the data in the same stage.
// busy is held low: the pipeline never stalls and the receiver cannot stall.
// Reset (synchronous, active low) clears the stage valid bits and loads the
// default key words and constant bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// simeck32_64_encrypt_core
// Fully unrolled Simeck32/64 encryption pipeline with configurable key words
// and key schedule constant bits.
// ----------------------------------------------------------------------------
module simeck32_64_encrypt_core #(
    parameter int ROUNDS = simeck_pkg::ROUNDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [simeck_pkg::HALF_W-1:0]       i_plain_left,
    input  logic [simeck_pkg::HALF_W-1:0]       i_plain_right,
    output logic                                o_valid,
    output logic [simeck_pkg::HALF_W-1:0]       o_cipher_left,
    output logic [simeck_pkg::HALF_W-1:0]       o_cipher_right,
    input  logic                                i_cfg_we,
    input  logic [simeck_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [simeck_pkg::HALF_W-1:0]       i_cfg_data
);

    localparam int W  = simeck_pkg::HALF_W;
    localparam int CB = simeck_pkg::CONST_BITS;
    // the last stage needs no key state after it
    localparam int KS = (ROUNDS > 1) ? ROUNDS - 1 : 1;

    // configuration registers
    logic [W-1:0]  r_key0, r_key1, r_key2, r_key3;
    logic [CB-1:0] r_const;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0  <= simeck_pkg::KEY0_RST;
            r_key1  <= simeck_pkg::KEY1_RST;
            r_key2  <= simeck_pkg::KEY2_RST;
            r_key3  <= simeck_pkg::KEY3_RST;
            r_const <= simeck_pkg::CONST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                simeck_pkg::CFG_KEY0:  r_key0  <= i_cfg_data;
                simeck_pkg::CFG_KEY1:  r_key1  <= i_cfg_data;
                simeck_pkg::CFG_KEY2:  r_key2  <= i_cfg_data;
                simeck_pkg::CFG_KEY3:  r_key3  <= i_cfg_data;
                simeck_pkg::CFG_CONST: r_const <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // z bits per round: configured bits, then the m-sequence recurrence
    logic [ROUNDS-1:0] w_z;

    for (genvar i = 0; i < ROUNDS; i++) begin : g_z
        if (i < CB) begin : g_cfg
            assign w_z[i] = r_const[i];
        end else begin : g_rec
            assign w_z[i] = w_z[i-3] ^ w_z[i-5];
        end
    end

    // pipeline stage registers
    logic [ROUNDS-1:0] r_vld;
    logic [W-1:0]      r_l  [ROUNDS];
    logic [W-1:0]      r_r  [ROUNDS];
    logic [W-1:0]      r_k  [KS];
    logic [W-1:0]      r_t0 [KS];
    logic [W-1:0]      r_t1 [KS];
    logic [W-1:0]      r_t2 [KS];

    logic [W-1:0]      n_l  [ROUNDS];
    logic [W-1:0]      n_r  [ROUNDS];
    logic [W-1:0]      n_k  [ROUNDS];
    logic [W-1:0]      n_t0 [ROUNDS];
    logic [W-1:0]      n_t1 [ROUNDS];
    logic [W-1:0]      n_t2 [ROUNDS];

    logic              w_accept;
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
        logic [W-1:0] l_in, r_in, k_in, t0_in, t1_in, t2_in;

        if (s == 0) begin : g_first
            assign l_in  = i_plain_left;
            assign r_in  = i_plain_right;
            assign k_in  = r_key0;
            assign t0_in = r_key1;
            assign t1_in = r_key2;
            assign t2_in = r_key3;
        end else begin : g_next
            assign l_in  = r_l[s-1];
            assign r_in  = r_r[s-1];
            assign k_in  = r_k[s-1];
            assign t0_in = r_t0[s-1];
            assign t1_in = r_t1[s-1];
            assign t2_in = r_t2[s-1];
        end

        always_comb begin
            n_l[s]  = simeck_pkg::mix(l_in) ^ r_in ^ k_in;
            n_r[s]  = l_in;
            n_k[s]  = t0_in;
            n_t0[s] = t1_in;
            n_t1[s] = t2_in;
            n_t2[s] = simeck_pkg::mix(t0_in) ^ k_in
                    ^ (simeck_pkg::CONST_BASE | {{(W-1){1'b0}}, w_z[s]});
        end

        always_ff @(posedge i_clk) begin
            r_l[s] <= n_l[s];
            r_r[s] <= n_r[s];
        end

        if (s < ROUNDS - 1) begin : g_key
            always_ff @(posedge i_clk) begin
                r_k[s]  <= n_k[s];
                r_t0[s] <= n_t0[s];
                r_t1[s] <= n_t1[s];
                r_t2[s] <= n_t2[s];
            end
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld[0] <= w_accept;
            for (int s = 1; s < ROUNDS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_valid        = r_vld[ROUNDS-1];
    assign o_cipher_left  = r_l[ROUNDS-1];
    assign o_cipher_right = r_r[ROUNDS-1];

    // every result word traces back to a matching start
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, ROUNDS))
        else $error("result strobe without matching start");

    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0) && !o_valid)
        else $error("stage valid bits not cleared by reset");

    a_first_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_r[0] == $past(i_plain_left)))
        else $error("right half of first stage not taken from left input");

endmodule

// ===== tb/simeck32_64_encrypt_core_tb.sv =====
// ----------------------------------------------------------------------------
// simeck32_64_encrypt_core_tb
// Drives plaintext words into the Simeck32/64 encryption pipeline under a
// series of key and round-constant settings. A scoreboard works out each
// ciphertext on its own and compares every o_valid strobe with the oldest one.
// ----------------------------------------------------------------------------
module simeck32_64_encrypt_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_W      = simeck_pkg::HALF_W;
    localparam int CONST_BITS  = simeck_pkg::CONST_BITS;
    localparam int CFG_IDX_W   = simeck_pkg::CFG_IDX_W;
    localparam int N_ROUNDS    = simeck_pkg::ROUNDS_DEF;
    localparam int IDX_LAST    = (1 << CFG_IDX_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 190;

    typedef struct packed {
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } t_half_pair;

    class t_cipher_scoreboard;
        logic [HALF_W-1:0]     key_w[4];
        logic [CONST_BITS-1:0] z_bits;
        t_half_pair            cipher_q[$];
        int                    errors;

        function new();
            key_w[0] = simeck_pkg::KEY0_RST;
            key_w[1] = simeck_pkg::KEY1_RST;
            key_w[2] = simeck_pkg::KEY2_RST;
            key_w[3] = simeck_pkg::KEY3_RST;
            z_bits   = simeck_pkg::CONST_RST;
            errors   = 0;
        endfunction

        // unknown indexes are dropped, the constant register keeps 14 bits
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] data);
            case (idx)
                simeck_pkg::CFG_KEY0:  key_w[0] = data;
                simeck_pkg::CFG_KEY1:  key_w[1] = data;
                simeck_pkg::CFG_KEY2:  key_w[2] = data;
                simeck_pkg::CFG_KEY3:  key_w[3] = data;
                simeck_pkg::CFG_CONST: z_bits   = data[CONST_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [HALF_W-1:0] feistel_f(logic [HALF_W-1:0] a);
            logic [HALF_W-1:0] r5;
            logic [HALF_W-1:0] r1;
            r5 = (a << 5) | (a >> (HALF_W - 5));
            r1 = (a << 1) | (a >> (HALF_W - 1));
            return (r5 & a) ^ r1;
        endfunction

        function t_half_pair encrypt_block(logic [HALF_W-1:0] pl, logic [HALF_W-1:0] pr);
            logic [HALF_W-1:0] l, r, k, t0, t1, t2, nl, nt;
            logic [4:0]        zwin;
            logic              z;
            t_half_pair        res;
            l    = pl;
            r    = pr;
            k    = key_w[0];
            t0   = key_w[1];
            t1   = key_w[2];
            t2   = key_w[3];
            zwin = '0;
            for (int i = 0; i < N_ROUNDS; i++) begin
                nl = feistel_f(l) ^ r ^ k;
                r  = l;
                l  = nl;
                // past the register the z bits follow the m-sequence recurrence
                if (i < CONST_BITS) begin
                    z = z_bits[i];
                end else begin
                    z = zwin[2] ^ zwin[0];
                end
                zwin = {z, zwin[4:1]};
                nt = feistel_f(t0) ^ k
                   ^ (simeck_pkg::CONST_BASE | {{(HALF_W-1){1'b0}}, z});
                k  = t0;
                t0 = t1;
                t1 = t2;
                t2 = nt;
            end
            res.left  = l;
            res.right = r;
            return res;
        endfunction

        function void note_plain(logic [HALF_W-1:0] pl, logic [HALF_W-1:0] pr);
            cipher_q.push_back(encrypt_block(pl, pr));
        endfunction

        function void check_cipher(logic [HALF_W-1:0] cl, logic [HALF_W-1:0] cr);
            t_half_pair exp_c;
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected word, actual left %h right %h", $time, cl, cr);
                errors++;
                return;
            end
            exp_c = cipher_q.pop_front();
            if (cl !== exp_c.left) begin
                $display("%0t: cipher_left mismatch, expected %h actual %h",
                         $time, exp_c.left, cl);
                errors++;
            end
            if (cr !== exp_c.right) begin
                $display("%0t: cipher_right mismatch, expected %h actual %h",
                         $time, exp_c.right, cr);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [HALF_W-1:0]     i_plain_left   = '0;
    logic [HALF_W-1:0]     i_plain_right  = '0;
    logic                  o_valid;
    logic [HALF_W-1:0]     o_cipher_left;
    logic [HALF_W-1:0]     o_cipher_right;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [HALF_W-1:0]     i_cfg_data     = '0;

    t_cipher_scoreboard sb = new();

    simeck32_64_encrypt_core #(
        .ROUNDS(N_ROUNDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_plain_left   (i_plain_left),
        .i_plain_right  (i_plain_right),
        .o_valid        (o_valid),
        .o_cipher_left  (o_cipher_left),
        .o_cipher_right (o_cipher_right),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_plain(i_plain_left, i_plain_right);
            end
            if (o_valid) begin
                sb.check_cipher(o_cipher_left, o_cipher_right);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // start is left high so back-to-back words need no extra edge
    task automatic send_word(input logic [HALF_W-1:0] pl, input logic [HALF_W-1:0] pr);
        start         <= 1'b1;
        i_plain_left  <= pl;
        i_plain_right <= pr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 11) begin
            idle_cycles(($urandom_range(0, 7) == 0) ? $urandom_range(2, 6) : 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] data);
        sb.write_reg(idx, data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (sb.cipher_q.size() != 0) @(posedge i_clk);
        repeat (N_ROUNDS + 4) @(posedge i_clk);
    endtask

    function automatic logic [HALF_W-1:0] pick_half();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 16'h0001 << $urandom_range(0, HALF_W - 1);
            3:       return ~(16'h0001 << $urandom_range(0, HALF_W - 1));
            default: return HALF_W'($urandom());
        endcase
    endfunction

    task automatic setup_phase(input int ph);
        logic [HALF_W-1:0] kv[4];
        logic [HALF_W-1:0] cv;
        for (int j = 0; j < 4; j++) begin
            kv[j] = (ph == 1) ? '0 : (ph == 2) ? '1 : pick_half();
        end
        // ones in the two bits above the constant register must be dropped
        cv = (ph == 1) ? '0 : (ph == 2) ? '1 : HALF_W'($urandom());
        write_reg(simeck_pkg::CFG_KEY0, kv[0]);
        write_reg(CFG_IDX_W'(IDX_LAST - $urandom_range(0,
                      IDX_LAST - int'(simeck_pkg::CFG_CONST) - 1)),
                  HALF_W'($urandom()));
        write_reg(simeck_pkg::CFG_KEY1, kv[1]);
        write_reg(simeck_pkg::CFG_KEY2, kv[2]);
        write_reg(simeck_pkg::CFG_KEY3, kv[3]);
        write_reg(simeck_pkg::CFG_CONST, cv);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [HALF_W-1:0] dir_words[13][2];
        dir_words = '{
            '{16'h0000, 16'h0000}, '{16'hffff, 16'hffff}, '{16'hffff, 16'h0000},
            '{16'h0000, 16'hffff}, '{16'h5555, 16'haaaa}, '{16'haaaa, 16'h5555},
            '{16'h8000, 16'h0001}, '{16'h0001, 16'h8000}, '{16'h0001, 16'h0000},
            '{16'h0000, 16'h0001}, '{16'h8000, 16'h8000}, '{16'h6565, 16'h6877},
            '{16'hfedc, 16'hba98}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner words under the reset key, with one gap and back to back
        for (int d = 0; d < 13; d++) begin
            send_word(dir_words[d][0], dir_words[d][1]);
            if (d == 5) idle_cycles(3);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                drain_pipe();
                setup_phase(ph);
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                maybe_gap(ph == 4);
                send_word(pick_half(), pick_half());
            end
        end

        drain_pipe();
        if (sb.cipher_q.size() != 0) begin
            $display("%0t: %0d words never came out", $time, sb.cipher_q.size());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/simeck_pkg.sv
rtl/simeck32_64_encrypt_core.sv
tb/simeck32_64_encrypt_core_tb.sv
